// File: sv/cds_pkg.sv
// Shared types, constants and date helper functions for the calendar date stepper.
// No dependencies; every other file of the block imports this package.
package cds_pkg;

    localparam int DAY_W      = 6;
    localparam int MON_W      = 4;
    localparam int OUT_YEAR_W = 14;
    localparam int OP_W       = 3;
    localparam int CNT_W      = 16;
    localparam int CNT_MAX    = (1 << CNT_W) - 1;

    localparam int RESET_YEAR = 1900;

    localparam logic [DAY_W-1:0] DAY_FIRST    = DAY_W'(1);
    localparam logic [DAY_W-1:0] DAYS_LONG    = DAY_W'(31);
    localparam logic [DAY_W-1:0] DAYS_SHORT   = DAY_W'(30);
    localparam logic [DAY_W-1:0] DAYS_FEB_LP  = DAY_W'(29);
    localparam logic [DAY_W-1:0] DAYS_FEB     = DAY_W'(28);
    localparam logic [MON_W-1:0] MON_JAN      = MON_W'(1);
    localparam logic [MON_W-1:0] MON_FEB      = MON_W'(2);
    localparam logic [MON_W-1:0] MON_APR      = MON_W'(4);
    localparam logic [MON_W-1:0] MON_JUN      = MON_W'(6);
    localparam logic [MON_W-1:0] MON_SEP      = MON_W'(9);
    localparam logic [MON_W-1:0] MON_NOV      = MON_W'(11);
    localparam logic [MON_W-1:0] MON_DEC      = MON_W'(12);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 3'd0,
        OP_NEXT = 3'd1,
        OP_PREV = 3'd2,
        OP_FWD  = 3'd3,
        OP_BACK = 3'd4
    } t_op;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Control strobes from the sequencer to the datapath.
    typedef struct packed {
        logic ready;        // block takes an item this cycle if one is offered
        logic accept;       // item taken this cycle
        logic step;         // shared unit advances the offset date
        logic done_direct;  // result of a load, single step or unused code goes out now
        logic done_offset;  // result of an offset walk goes out now
    } t_ctrl;

    function automatic logic is_short_month(input logic [MON_W-1:0] m);
        return (m == MON_APR) || (m == MON_JUN) || (m == MON_SEP) || (m == MON_NOV);
    endfunction

    function automatic logic date_ok(input logic [DAY_W-1:0] d,
                                     input logic [MON_W-1:0] m,
                                     input logic             leap);
        logic ok;
        ok = 1'b1;
        if (d < DAY_FIRST || d > DAYS_LONG || m < MON_JAN || m > MON_DEC) begin
            ok = 1'b0;
        end
        if (d > DAYS_SHORT && is_short_month(m)) begin
            ok = 1'b0;
        end
        if (d > DAYS_FEB_LP && m == MON_FEB) begin
            ok = 1'b0;
        end
        if (d > DAYS_FEB && m == MON_FEB && !leap) begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic             leap);
        logic [DAY_W-1:0] len;
        len = DAYS_LONG;
        if (is_short_month(m)) begin
            len = DAYS_SHORT;
        end else if (m == MON_FEB) begin
            len = leap ? DAYS_FEB_LP : DAYS_FEB;
        end
        return len;
    endfunction

endpackage

// File: sv/cds_if.sv
// Handshake channels of the calendar date stepper: request items and result items.
// Depends on cds_pkg for the field widths.
interface cds_in_if;
    import cds_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       operation;
    logic [DAY_W-1:0]      load_day;
    logic [MON_W-1:0]      load_month;
    logic [OUT_YEAR_W-1:0] load_year;
    logic [CNT_W-1:0]      day_count;

    modport source (output valid, operation, load_day, load_month, load_year, day_count,
                    input ready);
    modport sink   (input valid, operation, load_day, load_month, load_year, day_count,
                    output ready);
endinterface

interface cds_out_if;
    import cds_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DAY_W-1:0]      out_day;
    logic [MON_W-1:0]      out_month;
    logic [OUT_YEAR_W-1:0] out_year;
    logic                  date_valid;

    modport source (output valid, out_day, out_month, out_year, date_valid, input ready);
    modport sink   (input valid, out_day, out_month, out_year, date_valid, output ready);
endinterface

// File: sv/cds_step_unit.sv
// Shared one-day step unit: moves a date one day forward or backward.
// Depends on cds_pkg for the date checks and month lengths.
module cds_step_unit #(
    parameter int YEAR_BITS = 14
) (
    input  logic                       i_back,
    input  logic [cds_pkg::DAY_W-1:0]  i_day,
    input  logic [cds_pkg::MON_W-1:0]  i_month,
    input  logic [YEAR_BITS-1:0]       i_year,
    output logic [cds_pkg::DAY_W-1:0]  o_day,
    output logic [cds_pkg::MON_W-1:0]  o_month,
    output logic [YEAR_BITS-1:0]       o_year
);
    import cds_pkg::*;

    logic                 leap;
    logic [DAY_W-1:0]     t_day;
    logic [MON_W-1:0]     t_mon;
    logic [DAY_W-1:0]     w_day;
    logic [YEAR_BITS-1:0] y_next;

    // The leap bit only looks at the year, which does not change before the last check.
    assign leap   = (i_year[1:0] == 2'b00);
    assign t_day  = i_back ? (i_day - DAY_W'(1)) : (i_day + DAY_W'(1));
    assign t_mon  = i_back ? (i_month - MON_W'(1)) : (i_month + MON_W'(1));
    assign w_day  = i_back ? month_len(t_mon, leap) : DAY_FIRST;
    assign y_next = i_year + (i_back ? {YEAR_BITS{1'b1}} : YEAR_BITS'(1));

    always_comb begin
        o_day   = t_day;
        o_month = i_month;
        o_year  = i_year;
        if (!date_ok(t_day, i_month, leap)) begin
            o_day   = w_day;
            o_month = t_mon;
            if (!date_ok(w_day, t_mon, leap)) begin
                o_month = i_back ? MON_DEC : MON_JAN;
                o_year  = y_next;
            end
        end
    end

endmodule

// File: sv/cds_ctrl.sv
// Sequencer of the calendar date stepper: state machine and day counter for offset walks.
// Depends on cds_pkg for the state type and the control struct.
module cds_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_offset,
    input  logic [cds_pkg::CNT_W-1:0]  i_count,
    input  logic                       i_out_free,
    output cds_pkg::t_ctrl             o_ctrl
);
    import cds_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_ctrl            ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Outputs of the sequencer.
    always_comb begin
        ctrl = '0;
        case (r_state)
            ST_IDLE: begin
                ctrl.ready       = i_out_free;
                ctrl.accept      = i_out_free && i_in_valid;
                ctrl.done_direct = ctrl.accept && !i_offset;
            end
            ST_RUN: begin
                ctrl.step        = (r_cnt != '0);
                ctrl.done_offset = (r_cnt == '0) && i_out_free;
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

    // Next state and counter.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (ctrl.accept && i_offset) begin
                    n_state = ST_RUN;
                    n_cnt   = i_count;
                end
            end
            ST_RUN: begin
                if (ctrl.step) begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
                if (ctrl.done_offset) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ctrl = ctrl;

endmodule

// File: sv/calendar_date_stepper.sv
// Calendar date stepper top level: stored date, offset date, result register.
// Depends on cds_pkg, cds_if, cds_step_unit and cds_ctrl.
//
// The block keeps one date (day, month, year; 1/1/1900 after reset) and answers every
// request item with exactly one result item. Load, next-day and previous-day requests
// update the stored date in the cycle the item is accepted, and the result is presented
// in the next cycle. Offset requests (forward or backward by day_count days, saturated
// to MAX_OFFSET) walk a copy of the stored date one day per cycle through a single
// shared step unit, so such an item occupies the block until its result is written;
// the stored date is left untouched by the walk. Leap years are all years divisible by
// four, with no century exception, and the year wraps within YEAR_BITS bits. The
// date_valid flag of every result tells whether the stored date is a real calendar
// date. One request is worked on at a time: ready is low while an offset walk runs,
// and an item may be accepted while the previous result is being taken. There is no
// clearing pass after reset.
module calendar_date_stepper #(
    parameter int MAX_OFFSET = 65535,
    parameter int YEAR_BITS  = 14
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cds_in_if.sink    i_in,
    cds_out_if.source o_out
);
    import cds_pkg::*;

    // Saturation limit of the day counter.
    localparam int LIMIT = (MAX_OFFSET < CNT_MAX) ? MAX_OFFSET : CNT_MAX;

    t_ctrl                ctrl;
    logic                 offset_op;
    logic [CNT_W-1:0]     sat_count;
    logic                 out_free;

    // Stored date and the walking copy used by offset requests.
    logic [DAY_W-1:0]     r_cur_day, n_cur_day;
    logic [MON_W-1:0]     r_cur_mon, n_cur_mon;
    logic [YEAR_BITS-1:0] r_cur_year, n_cur_year;
    logic [DAY_W-1:0]     r_rep_day;
    logic [MON_W-1:0]     r_rep_mon;
    logic [YEAR_BITS-1:0] r_rep_year;
    logic                 r_back;

    // Result register.
    logic                  r_ovalid;
    logic [DAY_W-1:0]      r_oday;
    logic [MON_W-1:0]      r_omon;
    logic [OUT_YEAR_W-1:0] r_oyear;
    logic                  r_ook;

    // Shared step unit operands.
    logic                 su_back;
    logic [DAY_W-1:0]     su_day_i, su_day_o;
    logic [MON_W-1:0]     su_mon_i, su_mon_o;
    logic [YEAR_BITS-1:0] su_year_i, su_year_o;

    assign offset_op = (i_in.operation == OP_FWD) || (i_in.operation == OP_BACK);
    assign sat_count = (i_in.day_count > CNT_W'(LIMIT)) ? CNT_W'(LIMIT) : i_in.day_count;
    assign out_free  = !r_ovalid || o_out.ready;

    cds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_offset   (offset_op),
        .i_count    (sat_count),
        .i_out_free (out_free),
        .o_ctrl     (ctrl)
    );

    // The step unit serves the single-day requests while idle and the offset walk
    // while running; the two never need it in the same cycle.
    assign su_back   = ctrl.step ? r_back : (i_in.operation == OP_PREV);
    assign su_day_i  = ctrl.step ? r_rep_day  : r_cur_day;
    assign su_mon_i  = ctrl.step ? r_rep_mon  : r_cur_mon;
    assign su_year_i = ctrl.step ? r_rep_year : r_cur_year;

    cds_step_unit #(
        .YEAR_BITS (YEAR_BITS)
    ) u_step (
        .i_back  (su_back),
        .i_day   (su_day_i),
        .i_month (su_mon_i),
        .i_year  (su_year_i),
        .o_day   (su_day_o),
        .o_month (su_mon_o),
        .o_year  (su_year_o)
    );

    // New stored date for an accepted request.
    always_comb begin
        n_cur_day  = r_cur_day;
        n_cur_mon  = r_cur_mon;
        n_cur_year = r_cur_year;
        if (ctrl.accept) begin
            case (i_in.operation)
                OP_LOAD: begin
                    n_cur_day  = i_in.load_day;
                    n_cur_mon  = i_in.load_month;
                    n_cur_year = YEAR_BITS'(i_in.load_year);
                end
                OP_NEXT, OP_PREV: begin
                    n_cur_day  = su_day_o;
                    n_cur_mon  = su_mon_o;
                    n_cur_year = su_year_o;
                end
                default: begin
                    n_cur_day  = r_cur_day;
                    n_cur_mon  = r_cur_mon;
                    n_cur_year = r_cur_year;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_day  <= DAY_FIRST;
            r_cur_mon  <= MON_JAN;
            r_cur_year <= YEAR_BITS'(RESET_YEAR);
            r_ovalid   <= 1'b0;
        end else begin
            r_cur_day  <= n_cur_day;
            r_cur_mon  <= n_cur_mon;
            r_cur_year <= n_cur_year;
            if (ctrl.done_direct || ctrl.done_offset) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers: walking copy and result fields.
    always_ff @(posedge i_clk) begin
        if (ctrl.accept) begin
            r_rep_day  <= n_cur_day;
            r_rep_mon  <= n_cur_mon;
            r_rep_year <= n_cur_year;
            r_back     <= (i_in.operation == OP_BACK);
        end else if (ctrl.step) begin
            r_rep_day  <= su_day_o;
            r_rep_mon  <= su_mon_o;
            r_rep_year <= su_year_o;
        end
        if (ctrl.done_direct) begin
            r_oday  <= n_cur_day;
            r_omon  <= n_cur_mon;
            r_oyear <= OUT_YEAR_W'(n_cur_year);
            r_ook   <= date_ok(n_cur_day, n_cur_mon, n_cur_year[1:0] == 2'b00);
        end else if (ctrl.done_offset) begin
            r_oday  <= r_rep_day;
            r_omon  <= r_rep_mon;
            r_oyear <= OUT_YEAR_W'(r_rep_year);
            r_ook   <= date_ok(r_cur_day, r_cur_mon, r_cur_year[1:0] == 2'b00);
        end
    end

    assign i_in.ready       = ctrl.ready;
    assign o_out.valid      = r_ovalid;
    assign o_out.out_day    = r_oday;
    assign o_out.out_month  = r_omon;
    assign o_out.out_year   = r_oyear;
    assign o_out.date_valid = r_ook;

    // An item is only taken when the result register can hold its answer.
    a_accept_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> (!r_ovalid || o_out.ready))
        else $error("item accepted while an untaken result blocks the result register");

    // A result is never written over one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.done_direct || ctrl.done_offset) |-> (!r_ovalid || o_out.ready))
        else $error("result register overwritten before it was taken");

    // The shared unit is never claimed by an offset step and a new request at once.
    a_unit_shared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.step |-> (!ctrl.accept && !ctrl.ready))
        else $error("step unit claimed twice in one cycle");

    // An offset walk leaves the stored date alone.
    a_cur_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.step |=> ($stable(r_cur_day) && $stable(r_cur_mon) && $stable(r_cur_year)))
        else $error("stored date changed during an offset walk");

endmodule

// File: tb/calendar_date_stepper_tb.sv
// Self-checking testbench for the calendar date stepper: request and result channels.
// Depends on cds_pkg, cds_if and the calendar_date_stepper RTL with its step unit and sequencer.
module calendar_date_stepper_tb;
    import cds_pkg::*;

    localparam int MAX_OFFSET    = 65535;
    localparam int YEAR_BITS     = 14;
    localparam int YEAR_TOP      = (1 << YEAR_BITS) - 1;
    localparam int HOLD_CYCLES   = 100;        // long result hold-off in the pressure test
    localparam int SETTLE_CYCLES = 16;         // quiet time after the last result
    localparam int BIG_WALK_MAX  = 4;          // full-range offsets allowed in random items
    localparam int TIMEOUT_UNITS = 12_000_000; // time units before the hard stop

    // Operation codes that the block does not implement; they only report the stored date.
    localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    typedef struct packed {
        logic [DAY_W-1:0]     day;
        logic [MON_W-1:0]     month;
        logic [YEAR_BITS-1:0] year;
    } t_cal;

    typedef struct {
        logic [DAY_W-1:0]      day;
        logic [MON_W-1:0]      month;
        logic [OUT_YEAR_W-1:0] year;
        logic                  valid;
    } t_date_result;

    logic i_clk;
    logic i_rst_n;

    cds_in_if  req_if ();
    cds_out_if res_if ();

    calendar_date_stepper #(
        .MAX_OFFSET (MAX_OFFSET),
        .YEAR_BITS  (YEAR_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    // Predictor state: our own copy of the stored date, and the results still owed.
    t_cal         stored_date;
    t_date_result expected_dates[$];

    // Idle rates in percent per cycle for the two sides of the block.
    int send_idle_pct;
    int recv_idle_pct;

    // The pressure test bumps hold_requests; the receiver process notices and stalls.
    int hold_requests;

    int mismatch_count;
    int requests_sent;
    int results_checked;
    int offset_walks;
    int longest_walk;
    int big_walks_left;

    // ------------------------------------------------------------------
    // Calendar arithmetic of the predictor. Leap years are simply years
    // divisible by four, and every field wraps within its own width.
    // ------------------------------------------------------------------
    function automatic logic [DAY_W-1:0] days_in_month(input logic [MON_W-1:0]     m,
                                                       input logic [YEAR_BITS-1:0] y);
        case (m)
            MON_APR, MON_JUN, MON_SEP, MON_NOV: return DAYS_SHORT;
            MON_FEB: return (y[1:0] == 2'b00) ? DAYS_FEB_LP : DAYS_FEB;
            // Months outside 1..12 (0 in particular, i.e. December before January)
            // count as 31 days long.
            default: return DAYS_LONG;
        endcase
    endfunction

    function automatic logic is_real_date(input t_cal c);
        if (c.month < MON_JAN || c.month > MON_DEC) begin
            return 1'b0;
        end
        return (c.day >= DAY_FIRST) && (c.day <= days_in_month(c.month, c.year));
    endfunction

    // One day forward: bump the day; on overflow move to the first of the next
    // month, and past December to January of the next year.
    function automatic t_cal day_after(input t_cal c);
        t_cal n;
        n = c;
        n.day = n.day + DAY_W'(1);
        if (!is_real_date(n)) begin
            n.day   = DAY_FIRST;
            n.month = n.month + MON_W'(1);
            if (!is_real_date(n)) begin
                n.month = MON_JAN;
                n.year  = n.year + YEAR_BITS'(1);
            end
        end
        return n;
    endfunction

    // One day back: the mirror image. The length of the previous month is taken in
    // the current year, before any year correction.
    function automatic t_cal day_before(input t_cal c);
        t_cal n;
        n = c;
        n.day = n.day - DAY_W'(1);
        if (!is_real_date(n)) begin
            n.month = n.month - MON_W'(1);
            n.day   = days_in_month(n.month, n.year);
            if (!is_real_date(n)) begin
                n.month = MON_DEC;
                n.year  = n.year - YEAR_BITS'(1);
            end
        end
        return n;
    endfunction

    // Apply one accepted request to the stored date and queue the result it owes.
    function automatic void predict_date_result(input logic [OP_W-1:0]       op,
                                                input logic [DAY_W-1:0]      d,
                                                input logic [MON_W-1:0]      m,
                                                input logic [OUT_YEAR_W-1:0] y,
                                                input logic [CNT_W-1:0]      cnt);
        t_cal         walk;
        int           steps;
        t_date_result res;
        case (op)
            OP_LOAD: begin
                stored_date.day   = d;
                stored_date.month = m;
                stored_date.year  = YEAR_BITS'(y);
            end
            OP_NEXT: stored_date = day_after(stored_date);
            OP_PREV: stored_date = day_before(stored_date);
            default: ;
        endcase
        walk  = stored_date;
        steps = (int'(cnt) > MAX_OFFSET) ? MAX_OFFSET : int'(cnt);
        if (op == OP_FWD || op == OP_BACK) begin
            offset_walks++;
            if (steps > longest_walk) begin
                longest_walk = steps;
            end
        end
        if (op == OP_FWD) begin
            repeat (steps) walk = day_after(walk);
        end else if (op == OP_BACK) begin
            repeat (steps) walk = day_before(walk);
        end
        res.day   = walk.day;
        res.month = walk.month;
        res.year  = OUT_YEAR_W'(walk.year);
        res.valid = is_real_date(stored_date);
        expected_dates.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Mostly short walks, some of medium length, and a handful over the full range
    // so that the random part does not spend the whole run walking.
    function automatic logic [CNT_W-1:0] pick_day_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3 && big_walks_left > 0) begin
            big_walks_left--;
            return CNT_W'($urandom_range(0, CNT_MAX));
        end else if (r < 18) begin
            return CNT_W'($urandom_range(0, 1500));
        end
        return CNT_W'($urandom_range(0, 40));
    endfunction

    // Send one item. Valid is left high after acceptance; the next call either
    // drives the next item in the same step or lowers valid for an idle gap.
    task automatic send_request(input logic [OP_W-1:0]       op,
                                input logic [DAY_W-1:0]      d,
                                input logic [MON_W-1:0]      m,
                                input logic [OUT_YEAR_W-1:0] y,
                                input logic [CNT_W-1:0]      cnt);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.operation  <= op;
        req_if.load_day   <= d;
        req_if.load_month <= m;
        req_if.load_year  <= y;
        req_if.day_count  <= cnt;
        do @(posedge i_clk); while (!req_if.ready);
        predict_date_result(op, d, m, y, cnt);
        requests_sent++;
    endtask

    // Stop offering items and wait for every owed result to come out.
    task automatic pause_until_drained();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_dates.size() != 0);
    endtask

    // A real calendar date, biased toward month ends and the ends of the year range.
    task automatic send_random_load();
        logic [MON_W-1:0]      m;
        logic [OUT_YEAR_W-1:0] y;
        logic [DAY_W-1:0]      len;
        logic [DAY_W-1:0]      d;
        y = OUT_YEAR_W'($urandom_range(0, YEAR_TOP));
        if ($urandom_range(0, 9) == 0) begin
            y = $urandom_range(0, 1) ? OUT_YEAR_W'(YEAR_TOP) : '0;
        end
        m   = MON_W'($urandom_range(MON_JAN, MON_DEC));
        len = days_in_month(m, YEAR_BITS'(y));
        if ($urandom_range(0, 2) == 0) begin
            d = len - DAY_W'($urandom_range(0, 1));
        end else begin
            d = DAY_W'($urandom_range(DAY_FIRST, len));
        end
        send_request(OP_LOAD, d, m, y, CNT_W'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Hand-picked dates: reset value, leap February without the century rule,
    // month ends, year wrap in both directions, invalid stored dates including
    // the all-zero and all-one load fields, the unused operation codes and
    // zero-length and 366-day offsets.
    task automatic test_directed_dates();
        send_request(OP_RSVD5, '0, '0, '0, '0);             // reports 1/1/1900
        send_request(OP_PREV,  '0, '0, '0, '0);             // 31/12/1899
        send_request(OP_NEXT,  '0, '0, '0, '0);             // 1/1/1900 again
        send_request(OP_LOAD,  DAYS_FEB, MON_FEB, 14'd1900, '0);
        send_request(OP_NEXT,  '0, '0, '0, '0);             // 29/2, 1900 is a leap year here
        send_request(OP_NEXT,  '0, '0, '0, '0);             // 1/3/1900
        send_request(OP_LOAD,  DAYS_FEB, MON_FEB, 14'd1901, '0);
        send_request(OP_NEXT,  '0, '0, '0, '0);             // 1/3/1901
        send_request(OP_PREV,  '0, '0, '0, '0);             // 28/2/1901
        send_request(OP_LOAD,  DAYS_SHORT, MON_APR, 14'd2000, '0);
        send_request(OP_NEXT,  '0, '0, '0, '0);             // 1/5/2000
        send_request(OP_LOAD,  DAYS_LONG, MON_DEC, OUT_YEAR_W'(YEAR_TOP), '0);
        send_request(OP_NEXT,  '0, '0, '0, '0);             // year wraps to 0
        send_request(OP_PREV,  '0, '0, '0, '0);             // and back to the top year
        send_request(OP_LOAD,  '0, '0, '0, '0);             // invalid all-zero date
        send_request(OP_RSVD6, '0, '0, '0, '0);
        send_request(OP_PREV,  '0, '0, '0, '0);             // month 15 taken as 31 days
        send_request(OP_LOAD,  '1, '1, '1, '0);             // invalid all-ones date
        send_request(OP_NEXT,  '0, '0, '0, '0);             // day wraps to 0, lands 1/1/0
        send_request(OP_LOAD,  '1, '1, '1, '0);
        send_request(OP_PREV,  '0, '0, '0, '0);             // month 14 taken as 31 days
        send_request(OP_LOAD,  DAYS_LONG, MON_FEB, 14'd2001, '0);
        send_request(OP_RSVD7, '0, '0, '0, '0);             // still invalid, flag low
        send_request(OP_FWD,   '0, '0, '0, '0);             // zero-length walk
        send_request(OP_BACK,  '0, '0, '0, 16'd366);
        pause_until_drained();
    endtask

    // The longest walks the count field allows, forward and back again.
    task automatic test_long_walks();
        send_request(OP_LOAD, DAYS_FEB_LP, MON_FEB, 14'd2024, '0);
        send_request(OP_FWD,  '0, '0, '0, CNT_W'(CNT_MAX));
        send_request(OP_BACK, '0, '0, '0, CNT_W'(CNT_MAX));
    endtask

    // Mostly a load of a real date followed by a short run of steps and walks, with
    // the unused load fields random; the rest is noise with every field random.
    task automatic test_random_dates(input int count);
        int target;
        int run_len;
        target = requests_sent + count;
        while (requests_sent < target) begin
            if ($urandom_range(0, 4) == 0) begin
                send_request(OP_W'($urandom_range(0, 7)), DAY_W'($urandom), MON_W'($urandom),
                             OUT_YEAR_W'($urandom), pick_day_count());
            end else begin
                send_random_load();
                run_len = $urandom_range(1, 5);
                repeat (run_len) begin
                    send_request(OP_W'($urandom_range(OP_NEXT, OP_BACK)), DAY_W'($urandom),
                                 MON_W'($urandom), OUT_YEAR_W'($urandom), pick_day_count());
                end
            end
        end
    endtask

    // The receiver stops taking results for a long stretch while items keep coming,
    // so the block fills up and drops ready; then the sender waits for the backlog.
    task automatic test_result_backpressure();
        hold_requests++;
        repeat (4) begin
            send_random_load();
            send_request(OP_W'($urandom_range(OP_NEXT, OP_PREV)), '0, '0, '0, '0);
            send_request(OP_FWD, '0, '0, '0, CNT_W'($urandom_range(0, 3)));
        end
        pause_until_drained();
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and run sequence.
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        mismatch_count  = 0;
        requests_sent   = 0;
        results_checked = 0;
        offset_walks    = 0;
        longest_walk    = 0;
        hold_requests   = 0;
        big_walks_left  = BIG_WALK_MAX;
        send_idle_pct   = 15;
        recv_idle_pct   = 53;
        stored_date.day   = DAY_FIRST;
        stored_date.month = MON_JAN;
        stored_date.year  = YEAR_BITS'(RESET_YEAR);

        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.operation  <= OP_LOAD;
        req_if.load_day   <= '0;
        req_if.load_month <= '0;
        req_if.load_year  <= '0;
        req_if.day_count  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles a little, receiver a lot.
        test_directed_dates();
        test_long_walks();
        test_random_dates(20);

        // The other way round.
        send_idle_pct = 53;
        recv_idle_pct = 15;
        test_random_dates(20);

        // Neither side idles; the long hold-off comes from the pressure test alone.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_result_backpressure();
        test_random_dates(20);

        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d requests and %0d checked results, %0d offset walks up to %0d days",
                 requests_sent, results_checked, offset_walks, longest_walk);
        $display("all operation codes, leap and month-end rollovers, year wrap, invalid dates, stalls");
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Result side: random ready, except during a requested hold-off, which is counted
    // here so that its length does not depend on what the sender does.
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Every result taken is matched against the oldest owed result.
    initial begin
        t_date_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                if (expected_dates.size() == 0) begin
                    $error("unexpected result %0d/%0d/%0d with nothing outstanding",
                           res_if.out_day, res_if.out_month, res_if.out_year);
                    mismatch_count++;
                end else begin
                    want = expected_dates.pop_front();
                    check_field("out_day",    32'(want.day),   32'(res_if.out_day));
                    check_field("out_month",  32'(want.month), 32'(res_if.out_month));
                    check_field("out_year",   32'(want.year),  32'(res_if.out_year));
                    check_field("date_valid", 32'(want.valid), 32'(res_if.date_valid));
                    results_checked++;
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_UNITS);
        $error("timeout with %0d results still outstanding", expected_dates.size());
        $display("status: fail");
        $finish;
    end

endmodule
